// File: sv/bae_pkg.sv
package bae_pkg;

   // field widths
   localparam int unsigned BOUND_W = 32;
   localparam int unsigned PROB_W  = 16;
   localparam int unsigned BYTE_W  = 8;

   typedef logic [BOUND_W-1:0] bound_type;
   typedef logic [PROB_W-1:0]  prob_type;
   typedef logic [BYTE_W-1:0]  byte_type;

   // interval after reset
   localparam bound_type LOW_RESET  = 32'h0000_0000;
   localparam bound_type HIGH_RESET = 32'hffff_ffff;

   // item mode codes
   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_FLUSH  = 1'b1
   } mode_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MID,
      ST_EMIT,
      ST_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic update;
      logic shift_emit;
      logic final_emit;
      logic emit_last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic flush;
      logic shared;
      logic shared_next;
      logic out_free;
   } dp_status_type;

endpackage

// File: sv/bae_if.sv
// input item channel
interface bae_req_if;
   logic                valid;
   logic                ready;
   logic                mode;
   logic                bit_value;
   bae_pkg::prob_type   prob_one;

   modport source (output valid, output mode, output bit_value, output prob_one,
                   input ready);
   modport sink   (input valid, input mode, input bit_value, input prob_one,
                   output ready);
endinterface

// result item channel
interface bae_rsp_if;
   logic                valid;
   logic                ready;
   bae_pkg::byte_type   out_byte;
   logic                last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: sv/binary_arithmetic_encoder.sv
// channel   dir  handshake      payload
// req_port  in   valid / ready  mode, bit_value, prob_one[15:0]
// rsp_port  out  valid / ready  out_byte[7:0], last_of_run
//
// an encode item runs multiply, interval update, then emits each shared top
// byte (0 to 4 bytes), one per cycle while the result is taken, and ends
// when no shared byte is left
// a flush item emits the shared bytes and then the top byte of high
// synchronous active-high reset sets the interval to [0, 0xffffffff]
// a stalled result holds the byte loop; the next item is taken while it waits
module binary_arithmetic_encoder import bae_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bae_req_if.sink   req_port,
   bae_rsp_if.source rsp_port
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   bae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_mode  (req_port.mode),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // interval arithmetic and output register
   bae_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_port.mode),
      .req_bit_value   (req_port.bit_value),
      .req_prob_one    (req_port.prob_one),
      .rsp_valid       (rsp_port.valid),
      .rsp_ready       (rsp_port.ready),
      .rsp_out_byte    (rsp_port.out_byte),
      .rsp_last_of_run (rsp_port.last_of_run)
   );

endmodule

// File: sv/bae_ctrl.sv
module bae_ctrl import bae_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_mode,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_FLUSH) ? ST_EMIT : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_MID;
         end
         ST_MID: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.shared) begin
               state_in = status.flush ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_MID: begin
            cmd.update = 1'b1;
         end
         ST_EMIT: begin
            // shared top byte goes out; last only when encoding and none follows
            cmd.shift_emit = status.shared && status.out_free;
            cmd.emit_last  = !status.flush && !status.shared_next;
         end
         ST_FINAL: begin
            cmd.final_emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: sv/bae_datapath.sv
module bae_datapath import bae_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          req_mode,
   input  logic          req_bit_value,
   input  prob_type      req_prob_one,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output byte_type      rsp_out_byte,
   output logic          rsp_last_of_run
);

   bound_type low_ff, low_in;
   bound_type high_ff, high_in;
   logic      flush_ff, flush_in;
   logic      bit_ff, bit_in;
   prob_type  prob_ff, prob_in;
   bound_type prod_hi_ff, prod_hi_in;
   bound_type prod_lo_ff, prod_lo_in;
   logic      out_valid_ff, out_valid_in;
   byte_type  out_byte_ff, out_byte_in;
   logic      out_last_ff, out_last_in;

   bound_type span;
   bound_type mid;
   logic      out_free;

   // interval width and split point
   assign span = high_ff - low_ff;
   assign mid  = low_ff + prod_hi_ff + {16'h0000, prod_lo_ff[31:16]};

   // two 16x16 partial products of span * prob
   assign prod_hi_in = {16'h0000, span[31:16]} * {16'h0000, prob_ff};
   assign prod_lo_in = {16'h0000, span[15:0]} * {16'h0000, prob_ff};

   assign out_free = !out_valid_ff || rsp_ready;

   // status back to the controller
   assign status.flush       = flush_ff;
   assign status.shared      = (low_ff[31:24] == high_ff[31:24]);
   assign status.shared_next = (low_ff[23:16] == high_ff[23:16]);
   assign status.out_free    = out_free;

   // item capture
   always_comb begin
      flush_in = flush_ff;
      bit_in   = bit_ff;
      prob_in  = prob_ff;
      if (cmd.load) begin
         flush_in = (req_mode == MODE_FLUSH);
         bit_in   = req_bit_value;
         prob_in  = req_prob_one;
      end
   end

   // interval update and byte shift
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.update) begin
         if (bit_ff) begin
            high_in = mid;
         end else begin
            low_in = mid + 32'd1;
         end
      end else if (cmd.shift_emit) begin
         low_in  = {low_ff[23:0], 8'h00};
         high_in = {high_ff[23:0], 8'hff};
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.shift_emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = high_ff[31:24];
         out_last_in  = cmd.emit_last;
      end else if (cmd.final_emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = high_ff[31:24];
         out_last_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= LOW_RESET;
         high_ff      <= HIGH_RESET;
         out_valid_ff <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
         flush_ff     <= flush_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      prob_ff     <= prob_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (cmd.mul) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

// File: sv/bae_checker.sv
module bae_checker import bae_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_out_byte,
   input logic     rsp_last_of_run
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // an accepted item keeps the input closed after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input reopened too early");

   // results only appear while an item is being worked on
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   // more bytes of the same item follow a byte not marked last
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input open with run unfinished");

endmodule

bind binary_arithmetic_encoder bae_checker u_bae_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_out_byte    (rsp_port.out_byte),
   .rsp_last_of_run (rsp_port.last_of_run)
);
